// ===== src/sit_pkg.sv =====
// Shared types and constants of the sorted insertion table.
package sit_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int REQ_W  = 2;
	localparam int ID_W   = 20;
	localparam int AUX_W  = 17;
	localparam int KEY_W  = 30;
	localparam int RIDX_W = 6;
	localparam int ST_W   = 3;
	localparam int ECNT_W = 7;

	localparam int IN_BITS     = ID_W + AUX_W + KEY_W + RIDX_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = ID_W + AUX_W + KEY_W + ECNT_W;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int REQ_USER_W  = 8;
	localparam int ST_USER_W   = 8;

	// request codes; every code other than insert and clear decodes as a read
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	typedef enum logic [ST_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_READ_OK  = 3'd2,
		ST_BEYOND   = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AUX_W-1:0] aux;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		logic    accept;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    rd_in;
		logic    rd_scan;
		logic    wr_new;
		logic    wr_old;
		logic    idx_dec;
		logic    out_load;
		status_t status;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic idx_ok;
		logic idx_zero;
		logic key_ge;
	} sts_t;

endpackage

// ===== src/sit_ctrl.sv =====
// Request sequencer and result handshake of the sorted insertion table.
module sit_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sit_pkg::REQ_W-1:0]   req_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  sit_pkg::sts_t               sts,
	output sit_pkg::ctl_t               ctl
);

	sit_pkg::state_t  state_q, state_d;
	sit_pkg::status_t status_q, status_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sit_pkg::S_IDLE;
			status_q    <= sit_pkg::ST_INSERTED;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			status_q    <= status_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		ctl      = '0;
		ctl.status = status_q;
		in_ready = 1'b0;
		unique case (state_q)
			sit_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = sit_pkg::S_FIN;
					if (req_type == sit_pkg::REQ_INSERT) begin
						if (sts.full)
							status_d = sit_pkg::ST_DROPPED;
						else
							state_d = sit_pkg::S_INS_CHK;
					end else if (req_type == sit_pkg::REQ_CLEAR) begin
						ctl.cnt_clr = 1'b1;
						status_d    = sit_pkg::ST_CLEARED;
					end else begin
						ctl.rd_in = 1'b1;
						status_d  = sts.idx_ok ? sit_pkg::ST_READ_OK : sit_pkg::ST_BEYOND;
					end
				end
			end
			sit_pkg::S_INS_CHK: begin
				// top of the table reached: the new record lands here
				if (sts.idx_zero) begin
					ctl.wr_new  = 1'b1;
					ctl.cnt_inc = 1'b1;
					status_d    = sit_pkg::ST_INSERTED;
					state_d     = sit_pkg::S_FIN;
				end else begin
					ctl.rd_scan = 1'b1;
					state_d     = sit_pkg::S_INS_CMP;
				end
			end
			sit_pkg::S_INS_CMP: begin
				if (sts.key_ge) begin
					ctl.wr_new  = 1'b1;
					ctl.cnt_inc = 1'b1;
					status_d    = sit_pkg::ST_INSERTED;
					state_d     = sit_pkg::S_FIN;
				end else begin
					ctl.wr_old  = 1'b1;
					ctl.idx_dec = 1'b1;
					state_d     = sit_pkg::S_INS_CHK;
				end
			end
			sit_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = sit_pkg::S_IDLE;
				end
			end
			default: state_d = sit_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		if (ctl.out_load)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/sit_dpath.sv =====
// Table memory, entry count, scan index and result register.
module sit_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sit_pkg::ctl_t                ctl,
	output sit_pkg::sts_t                sts,
	input  logic [sit_pkg::ID_W-1:0]     item_id,
	input  logic [sit_pkg::AUX_W-1:0]    aux_count,
	input  logic [sit_pkg::KEY_W-1:0]    sort_key,
	input  logic [sit_pkg::RIDX_W-1:0]   read_index,
	output sit_pkg::status_t             status,
	output sit_pkg::entry_t              out_entry,
	output logic [sit_pkg::ECNT_W-1:0]   entry_count
);

	sit_pkg::entry_t             mem [sit_pkg::TABLE_DEPTH];
	sit_pkg::entry_t             new_q, rd_q, out_q;
	sit_pkg::status_t            status_q;
	logic [sit_pkg::CNT_W-1:0]   cnt_q, out_cnt_q;
	logic [sit_pkg::IDX_W-1:0]   idx_q, raddr;

	assign raddr = ctl.rd_in ? sit_pkg::IDX_W'(read_index) : idx_q - 1'b1;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_new || ctl.wr_old)
			mem[idx_q] <= ctl.wr_new ? new_q : rd_q;
		if (ctl.rd_in || ctl.rd_scan)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (ctl.cnt_clr)
			cnt_q <= '0;
		else if (ctl.cnt_inc)
			cnt_q <= cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			new_q <= '{key: sort_key, aux: aux_count, id: item_id};
			idx_q <= cnt_q[sit_pkg::IDX_W-1:0];
		end else if (ctl.idx_dec) begin
			idx_q <= idx_q - 1'b1;
		end
		if (ctl.out_load) begin
			status_q  <= ctl.status;
			out_cnt_q <= cnt_q;
			out_q     <= (ctl.status == sit_pkg::ST_READ_OK) ? rd_q : '0;
		end
	end

	assign sts.full     = (cnt_q == sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH));
	assign sts.idx_ok   = ((sit_pkg::CNT_W + sit_pkg::RIDX_W)'(read_index)
	                      < (sit_pkg::CNT_W + sit_pkg::RIDX_W)'(cnt_q));
	assign sts.idx_zero = (idx_q == '0);
	assign sts.key_ge   = (rd_q.key >= new_q.key);

	assign status      = status_q;
	assign out_entry   = out_q;
	assign entry_count = sit_pkg::ECNT_W'(out_cnt_q);

endmodule

// ===== src/sorted_insertion_table.sv =====
// Top level of the sorted insertion table: descending-key record store.
// Flow, accept to m_tvalid: read, clear and dropped insert go straight to the result; an insert
//   shifts S entries down one by one (shift step: read, write), then writes the record.
// Throughput: one item at a time; the next request is accepted only after the result loads,
//   and a result waits while an earlier one is held by a low m_tready.
// Reset: arst_n clears the entry count and handshake state; table memory is not cleared.
module sorted_insertion_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// item_id[19:0], aux_count[36:20], sort_key[66:37], read_index[72:67]
	input  logic [sit_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type[1:0]
	input  logic [sit_pkg::REQ_USER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_id[19:0], out_aux[36:20], out_key[66:37], entry_count[73:67]
	output logic [sit_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status[2:0]
	output logic [sit_pkg::ST_USER_W-1:0]     m_tuser
);

	sit_pkg::ctl_t                  ctl;
	sit_pkg::sts_t                  sts;
	sit_pkg::status_t               status;
	sit_pkg::entry_t                out_entry;
	logic [sit_pkg::ECNT_W-1:0]     entry_count;

	// unpack the request item
	logic [sit_pkg::ID_W-1:0]   item_id;
	logic [sit_pkg::AUX_W-1:0]  aux_count;
	logic [sit_pkg::KEY_W-1:0]  sort_key;
	logic [sit_pkg::RIDX_W-1:0] read_index;

	assign item_id    = s_tdata[19:0];
	assign aux_count  = s_tdata[36:20];
	assign sort_key   = s_tdata[66:37];
	assign read_index = s_tdata[72:67];

	sit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser[sit_pkg::REQ_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sit_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.item_id     (item_id),
		.aux_count   (aux_count),
		.sort_key    (sort_key),
		.read_index  (read_index),
		.status      (status),
		.out_entry   (out_entry),
		.entry_count (entry_count)
	);

	// pack the result item, zero fill to whole bytes
	assign m_tdata = {(sit_pkg::OUT_DATA_W - sit_pkg::OUT_BITS)'(0), entry_count,
	                  out_entry.key, out_entry.aux, out_entry.id};
	assign m_tuser = {(sit_pkg::ST_USER_W - sit_pkg::ST_W)'(0), status};

	// count never exceeds the table depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (entry_count <= sit_pkg::ECNT_W'(sit_pkg::TABLE_DEPTH)))
		else $error("entry count beyond table depth");

	// a clear leaves an empty table
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status == sit_pkg::ST_CLEARED) |-> (entry_count == '0))
		else $error("clear result with nonzero count");

	// only a successful read carries data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status != sit_pkg::ST_READ_OK) |-> (out_entry == '0))
		else $error("data on a result without read");

	// a successful insert leaves at least one entry
	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status == sit_pkg::ST_INSERTED) |-> (entry_count != '0))
		else $error("insert result with empty table");

endmodule
